### hdl/luhn_pkg.sv
package luhn_pkg;

    // Field widths
    localparam int unsigned CARD_W     = 64;
    localparam int unsigned CLS_W      = 2;
    localparam int unsigned DCNT_W     = 5;

    // Longest accepted number, in decimal digits (16 to 19)
    localparam int unsigned MAX_DIGITS = 19;
    localparam int unsigned BCD_W      = 4 * MAX_DIGITS;

    // Sequencer counter: one count per input bit, reused as digit index
    localparam int unsigned CNT_W      = $clog2(CARD_W);
    localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);

    // Lengths that select an issuer class
    localparam logic [DCNT_W-1:0] LEN_CLASS1  = DCNT_W'(15);
    localparam logic [DCNT_W-1:0] LEN_CLASS2  = DCNT_W'(16);
    localparam logic [DCNT_W-1:0] LEN_CLASS3A = DCNT_W'(13);
    localparam logic [DCNT_W-1:0] LEN_CLASS3B = DCNT_W'(16);

    // Issuer class codes
    localparam logic [CLS_W-1:0] CLS_NONE  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_LEN15 = 2'd1;
    localparam logic [CLS_W-1:0] CLS_LEN16 = 2'd2;
    localparam logic [CLS_W-1:0] CLS_LEAD4 = 2'd3;

    // 10^MAX_DIGITS, worked out at elaboration
    function automatic logic [CARD_W-1:0] digit_limit();
        logic [CARD_W-1:0] lim;
        lim = CARD_W'(1);
        for (int k = 0; k < MAX_DIGITS; k++) begin
            lim = CARD_W'(lim * CARD_W'(10));
        end
        return lim;
    endfunction

    localparam logic [CARD_W-1:0] DIGIT_LIMIT = digit_limit();

    // Doubled digit with its two decimal digits added
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [3:0] r;
        case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_DIGIT,
        S_FIN
    } t_state;

endpackage

### hdl/luhn_card_number_checker.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------------
// input    | in        | i_valid / o_ready   | i_card_number
// result   | out       | o_valid / i_ready   | o_issuer_class, o_checksum_ok, o_digit_count
//
// An item passes from its transfer to the loaded result through 64 bit-serial binary to BCD
// steps, one digit per cycle through the Luhn sum, and a load in the finish state; the next
// input is taken once the sequencer is back in idle.
// A number of 10^MAX_DIGITS or more skips both passes and goes straight to the load.
// Input is taken only while idle; a finished item stalls until the result register is
// free, and a new item can run while a result waits. Reset is synchronous, active low.
module luhn_card_number_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [luhn_pkg::CARD_W-1:0]   i_card_number,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [luhn_pkg::CLS_W-1:0]    o_issuer_class,
    output logic                          o_checksum_ok,
    output logic [luhn_pkg::DCNT_W-1:0]   o_digit_count
);

    luhn_pkg::t_state r_state, n_state;

    logic [luhn_pkg::CNT_W-1:0]   r_cnt;
    logic [luhn_pkg::CARD_W-1:0]  r_bin;
    logic [luhn_pkg::BCD_W-1:0]   r_bcd;
    logic                         r_ovf;
    logic [3:0]                   r_sum;
    logic [luhn_pkg::DCNT_W-1:0]  r_dcount;
    logic [3:0]                   r_lead;
    logic [3:0]                   r_second;
    logic [3:0]                   r_prev;

    logic                         r_out_valid;
    logic [luhn_pkg::CLS_W-1:0]   r_cls;
    logic                         r_ok;
    logic [luhn_pkg::DCNT_W-1:0]  r_out_cnt;

    logic                         in_xfer;
    logic                         conv_last;
    logic                         digit_last;
    logic                         out_free;
    logic                         ovf_in;
    logic [luhn_pkg::BCD_W-1:0]   bcd_adj;
    logic [3:0]                   dig;
    logic [3:0]                   dig_val;
    logic [4:0]                   sum_raw;
    logic [3:0]                   n_sum;
    logic                         sum_ok;
    logic [luhn_pkg::CLS_W-1:0]   cls;

    // Handshake and sequencing conditions
    assign in_xfer    = i_valid && o_ready;
    assign out_free   = !r_out_valid || i_ready;
    assign conv_last  = (r_cnt == luhn_pkg::CNT_W'(luhn_pkg::CARD_W - 1));
    assign digit_last = (r_cnt == luhn_pkg::CNT_W'(luhn_pkg::MAX_DIGITS - 1));
    assign ovf_in     = (i_card_number >= luhn_pkg::DIGIT_LIMIT);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            luhn_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = ovf_in ? luhn_pkg::S_FIN : luhn_pkg::S_CONV;
                end
            end
            luhn_pkg::S_CONV: begin
                if (conv_last) begin
                    n_state = luhn_pkg::S_DIGIT;
                end
            end
            luhn_pkg::S_DIGIT: begin
                if (digit_last) begin
                    n_state = luhn_pkg::S_FIN;
                end
            end
            luhn_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = luhn_pkg::S_IDLE;
                end
            end
            default: n_state = luhn_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        case (r_state)
            luhn_pkg::S_IDLE: o_ready = 1'b1;
            default:          o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= luhn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Add-3 adjust on every BCD digit before the shift
    always_comb begin
        for (int i = 0; i < luhn_pkg::MAX_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                          : r_bcd[4*i +: 4];
        end
    end

    // Luhn sum modulo ten, one digit per cycle from the low end
    assign dig     = r_bcd[3:0];
    assign dig_val = r_cnt[0] ? luhn_pkg::luhn_dbl(dig) : dig;
    assign sum_raw = {1'b0, r_sum} + {1'b0, dig_val};
    assign n_sum   = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];

    // Issuer class from length and leading digits, set only when the checksum passes
    assign sum_ok = (r_sum == 4'd0);
    always_comb begin
        cls = luhn_pkg::CLS_NONE;
        if (sum_ok) begin
            if (r_dcount == luhn_pkg::LEN_CLASS1 && r_lead == 4'd3
                && (r_second == 4'd4 || r_second == 4'd7)) begin
                cls = luhn_pkg::CLS_LEN15;
            end else if (r_dcount == luhn_pkg::LEN_CLASS2 && r_lead == 4'd5
                && r_second inside {[4'd1:4'd5]}) begin
                cls = luhn_pkg::CLS_LEN16;
            end else if ((r_dcount == luhn_pkg::LEN_CLASS3A
                || r_dcount == luhn_pkg::LEN_CLASS3B) && r_lead == 4'd4) begin
                cls = luhn_pkg::CLS_LEAD4;
            end
        end
    end

    // Datapath: converter shift registers and digit pass
    always_ff @(posedge i_clk) begin
        case (r_state)
            luhn_pkg::S_IDLE: begin
                if (in_xfer) begin
                    r_bin    <= i_card_number;
                    r_bcd    <= '0;
                    r_ovf    <= ovf_in;
                    r_cnt    <= '0;
                    r_sum    <= 4'd0;
                    r_dcount <= luhn_pkg::DCNT_W'(1);
                    r_lead   <= 4'd0;
                    r_second <= 4'd0;
                    r_prev   <= 4'd0;
                end
            end
            luhn_pkg::S_CONV: begin
                r_bcd <= {bcd_adj[luhn_pkg::BCD_W-2:0], r_bin[luhn_pkg::CARD_W-1]};
                r_bin <= {r_bin[luhn_pkg::CARD_W-2:0], 1'b0};
                r_cnt <= conv_last ? '0 : r_cnt + luhn_pkg::CNT_W'(1);
            end
            luhn_pkg::S_DIGIT: begin
                r_sum  <= n_sum;
                r_prev <= dig;
                if (dig != 4'd0) begin
                    r_dcount <= luhn_pkg::DCNT_W'(r_cnt[luhn_pkg::IDX_W-1:0])
                              + luhn_pkg::DCNT_W'(1);
                    r_lead   <= dig;
                    r_second <= r_prev;
                end
                r_bcd <= {4'd0, r_bcd[luhn_pkg::BCD_W-1:4]};
                r_cnt <= r_cnt + luhn_pkg::CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == luhn_pkg::S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == luhn_pkg::S_FIN && out_free) begin
            r_cls     <= r_ovf ? luhn_pkg::CLS_NONE : cls;
            r_ok      <= r_ovf ? 1'b0 : sum_ok;
            r_out_cnt <= r_ovf ? '0 : r_dcount;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_issuer_class = r_cls;
    assign o_checksum_ok  = r_ok;
    assign o_digit_count  = r_out_cnt;

    // A class is only reported for a passing checksum
    a_cls_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_issuer_class != luhn_pkg::CLS_NONE) |-> o_checksum_ok)
        else $error("issuer class set without passing checksum");

    // Overflow result carries all-zero fields
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_digit_count == '0) |->
            (!o_checksum_ok && o_issuer_class == luhn_pkg::CLS_NONE))
        else $error("zero digit count with nonzero fields");

    // Digit count stays within range
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_count <= luhn_pkg::DCNT_W'(luhn_pkg::MAX_DIGITS)))
        else $error("digit count out of range");

    // Conversion runs its full bit count before the digit pass
    a_conv_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == luhn_pkg::S_CONV && !conv_last) |=> (r_state == luhn_pkg::S_CONV))
        else $error("conversion left early");

endmodule
